// ----- rtl/core/amf_pkg.sv -----
// Shared constants and types of the adaptive median filter.
package amf_pkg;

   localparam int MaxWindow = 11;
   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;

   localparam int CfgW      = 11;
   localparam int CfgIdxW   = 2;
   localparam int LimitW    = 4;

   localparam logic [CfgIdxW-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CfgIdxW-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CfgIdxW-1:0] CSR_LIMIT  = 2'd2;

   localparam logic [CfgW-1:0]   WidthReset  = 11'd512;
   localparam logic [CfgW-1:0]   HeightReset = 11'd512;
   localparam logic [LimitW-1:0] LimitReset  = 4'd11;

   localparam logic [1:0] DEC_KEEP   = 2'd0;
   localparam logic [1:0] DEC_MEDIAN = 2'd1;
   localparam logic [1:0] DEC_NONE   = 2'd2;

   typedef struct packed {
      logic       init;
      logic       sample_en;
      logic       plane_done;
      logic [2:0] plane;
   } amf_rank_ctl_type;

endpackage

// ----- rtl/core/amf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module amf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/amf_rank.sv -----
// One colour channel: running min/max and bit-serial radix selection of the median.
module amf_rank #(
   parameter int CNT_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  amf_pkg::amf_rank_ctl_type ctl,
   input  logic [CNT_W-1:0]        rank,
   input  logic [7:0]              sample,
   output logic [7:0]              min_val,
   output logic [7:0]              max_val,
   output logic [7:0]              median
);

   logic [7:0]       min_ff, min_in, max_ff, max_in, prefix_ff, prefix_in;
   logic [CNT_W-1:0] rank_ff, rank_in, cnt_ff, cnt_in;
   logic [8:0]       hi_mask;
   logic             match;

   always_comb begin
      hi_mask   = 9'h1FF << ({1'b0, ctl.plane} + 4'd1);
      match     = ((sample ^ prefix_ff) & hi_mask[7:0]) == 8'd0;
      min_in    = min_ff;
      max_in    = max_ff;
      prefix_in = prefix_ff;
      rank_in   = rank_ff;
      cnt_in    = cnt_ff;
      if (ctl.init) begin
         min_in    = 8'hFF;
         max_in    = 8'h00;
         prefix_in = 8'h00;
         rank_in   = rank;
         cnt_in    = '0;
      end else if (ctl.sample_en) begin
         if (sample < min_ff) min_in = sample;
         if (sample > max_ff) max_in = sample;
         if (match && !sample[ctl.plane]) cnt_in = cnt_ff + 1'b1;
      end else if (ctl.plane_done) begin
         // rank falls among the zeros of this plane, or skip past them
         if (rank_ff >= cnt_ff) begin
            prefix_in[ctl.plane] = 1'b1;
            rank_in              = rank_ff - cnt_ff;
         end
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      min_ff    <= min_in;
      max_ff    <= max_in;
      prefix_ff <= prefix_in;
      rank_ff   <= rank_in;
   end

   assign min_val = min_ff;
   assign max_val = max_ff;
   assign median  = prefix_ff;

endmodule

// ----- rtl/core/adaptive_median_filter_rgb.sv -----
// Top level of the adaptive median filter for raster-order RGB pixels.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  pixel_red/green/blue, flush_tick
//   rsp_      out        rsp_valid/rsp_stall  out_red/green/blue, decision, frame_last
//   csr_      in         csr_write_enable     csr_index, csr_write_data
//
// A request that yields no pixel returns to idle after the check. One that yields
// a pixel reads its centre, then tries window sides 2s+1 in turn:
// every side runs eight passes over its samples, one line-store read a cycle.
// Reset is synchronous; the line store is not cleared, each entry is written
// before it is read within a frame. req_stall stays high while a request is in
// work or a result waits on rsp_stall.
module adaptive_median_filter_rgb #(
   parameter int MAX_WINDOW = amf_pkg::MaxWindow,
   parameter int MAX_WIDTH  = amf_pkg::MaxWidth,
   parameter int MAX_HEIGHT = amf_pkg::MaxHeight
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_pixel_red,
   input  logic [7:0]                 req_pixel_green,
   input  logic [7:0]                 req_pixel_blue,
   input  logic                       req_flush_tick,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_red,
   output logic [7:0]                 rsp_out_green,
   output logic [7:0]                 rsp_out_blue,
   output logic [1:0]                 rsp_decision,
   output logic                       rsp_frame_last,
   input  logic                       csr_write_enable,
   input  logic [amf_pkg::CfgIdxW-1:0] csr_index,
   input  logic [amf_pkg::CfgW-1:0]   csr_write_data
);

   localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
   localparam int SIDE_MAX = 2 * HALF_MAX + 1;
   localparam int RING     = 2 * HALF_MAX + 2;
   localparam int DEPTH    = RING * MAX_WIDTH;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int RW       = $clog2(MAX_HEIGHT + 1);
   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int SW       = $clog2(RING);
   localparam int HW       = $clog2(HALF_MAX + 1);
   localparam int DW       = HW + 2;
   localparam int NW       = $clog2(SIDE_MAX * SIDE_MAX + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_CREAD = 4'd2;
   localparam logic [3:0] ST_CWAIT = 4'd3;
   localparam logic [3:0] ST_INIT  = 4'd4;
   localparam logic [3:0] ST_SCAN  = 4'd5;
   localparam logic [3:0] ST_DRAIN = 4'd6;
   localparam logic [3:0] ST_PLANE = 4'd7;
   localparam logic [3:0] ST_EVAL  = 4'd8;

   // configuration
   logic [amf_pkg::CfgW-1:0]   width_ff, height_ff;
   logic [amf_pkg::LimitW-1:0] limit_ff;

   // positions
   logic [CW-1:0] col_ff, col_in, ocol_ff, ocol_in;
   logic [RW-1:0] row_ff, row_in, orow_ff, orow_in;
   logic [SW-1:0] islot_ff, islot_in, oslot_ff, oslot_in;

   // control
   logic [3:0]           state_ff, state_in;
   logic [HW-1:0]        side_ff, side_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [2:0]           plane_ff, plane_in;
   logic                 sample_en_ff;
   logic [23:0]          centre_ff, centre_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [1:0] dec_ff, dec_in;
   logic       last_ff, last_in;

   logic [WW-1:0] eff_w;
   logic [RW-1:0] eff_h;
   logic [HW-1:0] half_lim;
   logic [NW-1:0] rank;
   logic          req_accept, px_write, due, neg_side;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [23:0]   rd_data;

   amf_pkg::amf_rank_ctl_type ctl;
   logic [7:0] mn [3];
   logic [7:0] md [3];
   logic [7:0] mx [3];
   logic       med_in, pix_in;

   // effective sizes
   always_comb begin
      int wi, hi, lv, nn;
      wi = int'(width_ff);
      hi = int'(height_ff);
      lv = int'(limit_ff);
      if (wi < 1) wi = 1;
      if (wi > MAX_WIDTH) wi = MAX_WIDTH;
      if (hi < 1) hi = 1;
      if (hi > MAX_HEIGHT) hi = MAX_HEIGHT;
      if ((lv % 2) == 0) lv = (lv == 0) ? 1 : lv - 1;
      if (lv > SIDE_MAX) lv = SIDE_MAX;
      eff_w    = WW'(wi);
      eff_h    = RW'(hi);
      half_lim = HW'((lv - 1) / 2);
      nn       = (2 * int'(side_ff) + 1) * (2 * int'(side_ff) + 1);
      rank     = NW'(nn / 2);
   end

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign px_write   = req_accept && !req_flush_tick && (row_ff < eff_h);
   assign wr_addr    = AW'(int'(islot_ff) * MAX_WIDTH + int'(col_ff));

   // output is due once its farthest neighbor has arrived
   always_comb begin
      int nx, ny;
      nx = int'(ocol_ff) + HALF_MAX;
      ny = int'(orow_ff) + HALF_MAX;
      if (nx > int'(eff_w) - 1) nx = int'(eff_w) - 1;
      if (ny > int'(eff_h) - 1) ny = int'(eff_h) - 1;
      due = (row_ff >= eff_h) || (int'(row_ff) > ny)
            || ((int'(row_ff) == ny) && (int'(col_ff) > nx));
   end

   // window sample address with edge replication and ring slot
   always_comb begin
      int xi, yi, si;
      xi = int'(ocol_ff) + int'(dx_ff);
      yi = int'(orow_ff) + int'(dy_ff);
      if (xi < 0) xi = 0;
      if (xi > int'(eff_w) - 1) xi = int'(eff_w) - 1;
      if (yi < 0) yi = 0;
      if (yi > int'(eff_h) - 1) yi = int'(eff_h) - 1;
      si = int'(oslot_ff) + (yi - int'(orow_ff));
      if (si < 0) si = si + RING;
      else if (si >= RING) si = si - RING;
      rd_addr = AW'(si * MAX_WIDTH + xi);
   end

   amf_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (px_write),
      .wr_addr (wr_addr),
      .wr_data ({req_pixel_red, req_pixel_green, req_pixel_blue}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      ctl.init       = (state_ff == ST_INIT);
      ctl.sample_en  = sample_en_ff;
      ctl.plane_done = (state_ff == ST_PLANE);
      ctl.plane      = plane_ff;
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      amf_rank #(
         .CNT_W (NW)
      ) u_rank (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .rank    (rank),
         .sample  (rd_data[23-8*c -: 8]),
         .min_val (mn[c]),
         .max_val (mx[c]),
         .median  (md[c])
      );
   end

   always_comb begin
      med_in = 1'b1;
      pix_in = 1'b1;
      for (int c = 0; c < 3; c++) begin
         if (!(md[c] > mn[c] && md[c] < mx[c])) med_in = 1'b0;
         if (!(centre_ff[23-8*c -: 8] > mn[c] && centre_ff[23-8*c -: 8] < mx[c])) begin
            pix_in = 1'b0;
         end
      end
   end

   assign neg_side = 1'b1;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      islot_in     = islot_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      oslot_in     = oslot_ff;
      side_in      = side_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      plane_in     = plane_ff;
      centre_in    = centre_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      dec_in       = dec_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (px_write) begin
               // advance the input position
               if (int'(col_ff) + 1 >= int'(eff_w)) begin
                  col_in   = '0;
                  row_in   = row_ff + 1'b1;
                  islot_in = (int'(islot_ff) == RING - 1) ? '0 : islot_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            if (req_accept) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (orow_ff >= eff_h || !due) state_in = ST_IDLE;
            else begin
               dx_in    = '0;
               dy_in    = '0;
               state_in = ST_CREAD;
            end
         end
         ST_CREAD: state_in = ST_CWAIT;
         ST_CWAIT: begin
            centre_in = rd_data;
            side_in   = '0;
            state_in  = ST_INIT;
         end
         ST_INIT: begin
            dx_in    = -DW'(side_ff);
            dy_in    = -DW'(side_ff);
            plane_in = 3'd7;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (dx_ff == DW'(side_ff)) begin
               dx_in = -DW'(side_ff);
               if (dy_ff == DW'(side_ff)) state_in = ST_DRAIN;
               else dy_in = dy_ff + 1'b1;
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_PLANE;
         ST_PLANE: begin
            if (plane_ff == 3'd0) state_in = ST_EVAL;
            else begin
               plane_in = plane_ff - 1'b1;
               dx_in    = -DW'(side_ff);
               dy_in    = -DW'(side_ff);
               state_in = ST_SCAN;
            end
         end
         ST_EVAL: begin
            if (!med_in && side_ff < half_lim) begin
               side_in  = side_ff + 1'b1;
               state_in = ST_INIT;
            end else begin
               rsp_valid_in = 1'b1;
               if (med_in && !pix_in) begin
                  {red_in, green_in, blue_in} = {md[0], md[1], md[2]};
                  dec_in = amf_pkg::DEC_MEDIAN;
               end else begin
                  {red_in, green_in, blue_in} = centre_ff;
                  dec_in = med_in ? amf_pkg::DEC_KEEP : amf_pkg::DEC_NONE;
               end
               last_in = (int'(orow_ff) == int'(eff_h) - 1)
                         && (int'(ocol_ff) == int'(eff_w) - 1);
               // advance the output position, restart after the frame
               if (int'(ocol_ff) + 1 >= int'(eff_w)) begin
                  ocol_in = '0;
                  if (int'(orow_ff) + 1 >= int'(eff_h)) begin
                     orow_in  = '0;
                     oslot_in = '0;
                     col_in   = '0;
                     row_in   = '0;
                     islot_in = '0;
                  end else begin
                     orow_in  = orow_ff + 1'b1;
                     oslot_in = (int'(oslot_ff) == RING - 1) ? '0 : oslot_ff + 1'b1;
                  end
               end else begin
                  ocol_in = ocol_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write_enable && (csr_index == amf_pkg::CSR_WIDTH
            || csr_index == amf_pkg::CSR_HEIGHT || csr_index == amf_pkg::CSR_LIMIT)
            && neg_side) begin
         // a write to the width, height or limit register abandons the frame
         col_in   = '0;
         row_in   = '0;
         islot_in = '0;
         ocol_in  = '0;
         orow_in  = '0;
         oslot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= amf_pkg::WidthReset;
         height_ff    <= amf_pkg::HeightReset;
         limit_ff     <= amf_pkg::LimitReset;
         col_ff       <= '0;
         row_ff       <= '0;
         islot_ff     <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         oslot_ff     <= '0;
         side_ff      <= '0;
         sample_en_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         islot_ff     <= islot_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         oslot_ff     <= oslot_in;
         side_ff      <= side_in;
         sample_en_ff <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               amf_pkg::CSR_WIDTH:  width_ff  <= csr_write_data;
               amf_pkg::CSR_HEIGHT: height_ff <= csr_write_data;
               amf_pkg::CSR_LIMIT:  limit_ff  <= csr_write_data[amf_pkg::LimitW-1:0];
               default: ;
            endcase
         end
      end
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      plane_ff  <= plane_in;
      centre_ff <= centre_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      dec_ff    <= dec_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = red_ff;
   assign rsp_out_green  = green_ff;
   assign rsp_out_blue   = blue_ff;
   assign rsp_decision   = dec_ff;
   assign rsp_frame_last = last_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (state_ff == ST_IDLE && !rsp_valid_ff))
      else $error("request taken while busy");

   a_result_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EVAL)
      else $error("result raised outside evaluation");

   a_side_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> side_ff <= half_lim)
      else $error("window side beyond limit");

   a_decision_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dec_ff == amf_pkg::DEC_KEEP || dec_ff == amf_pkg::DEC_MEDIAN
                        || dec_ff == amf_pkg::DEC_NONE))
      else $error("bad decision code");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the adaptive median filter: directed table, then random frames.
`timescale 1ns / 100ps

module tb_top;

   localparam int RingRows = 2 * ((amf_pkg::MaxWindow - 1) / 2) + 2;
   localparam int HalfMax  = (amf_pkg::MaxWindow - 1) / 2;
   localparam int SideMax  = 2 * HalfMax + 1;
   localparam int Settle   = 3000;
   localparam logic [amf_pkg::CfgIdxW-1:0] CsrUnused = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] decision;
      logic       frame_last;
   } pixel_result_type;

   typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [1:0]       reg_index;
      logic [10:0]      reg_data;
      logic [7:0]       red, green, blue;
      logic             flush;
      bit               typed;        // expectation given below instead of predicted
      bit               has_result;
      pixel_result_type result;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_pixel_red = '0, req_pixel_green = '0, req_pixel_blue = '0;
   logic          req_flush_tick = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [7:0]    rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [1:0]    rsp_decision;
   logic          rsp_frame_last;
   logic          csr_write_enable = 1'b0;
   logic [amf_pkg::CfgIdxW-1:0] csr_index = '0;
   logic [amf_pkg::CfgW-1:0]    csr_write_data = '0;

   adaptive_median_filter_rgb DUT (.*);

   always #6 clock = ~clock;

   // Predictor state: line ring, registers and the input / output raster positions.
   logic [23:0]  line_ring [RingRows*amf_pkg::MaxWidth];
   int unsigned  reg_width, reg_height, reg_limit;
   int unsigned  in_col, in_row, out_col, out_row;

   pixel_result_type filtered_q[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  send_idle = 31, recv_idle = 65;
   int  hold_req = 0, hold_seen = 0;
   int  hold_cnt = 0;
   logic [7:0] base_level;

   function automatic int unsigned width_used();
      return reg_width < 1 ? 1 : (reg_width > amf_pkg::MaxWidth ? amf_pkg::MaxWidth : reg_width);
   endfunction

   function automatic int unsigned height_used();
      return reg_height < 1 ? 1
             : (reg_height > amf_pkg::MaxHeight ? amf_pkg::MaxHeight : reg_height);
   endfunction

   function automatic int unsigned side_limit();
      int unsigned v;
      v = reg_limit;
      if (v[0] == 1'b0) v = (v == 0) ? 1 : v - 1;
      if (v > SideMax) v = SideMax;
      return v;
   endfunction

   function automatic logic [23:0] ring_read(int x, int y);
      return line_ring[(y % RingRows) * amf_pkg::MaxWidth + x];
   endfunction

   function automatic void restart_raster();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
   endfunction

   function automatic void update_register(logic [1:0] idx, logic [10:0] data);
      case (idx)
         amf_pkg::CSR_WIDTH:  reg_width  = data;
         amf_pkg::CSR_HEIGHT: reg_height = data;
         amf_pkg::CSR_LIMIT:  reg_limit  = data[3:0];
         default:             return;
      endcase
      restart_raster();
   endfunction

   function automatic bit raster_busy();
      return (in_col | in_row | out_col | out_row) != 0;
   endfunction

   // Try windows of growing odd side around (ox, oy) and pick the filtered pixel.
   function automatic pixel_result_type filter_at(int ox, int oy, int w, int h);
      pixel_result_type res;
      logic [23:0]   centre, win [SideMax*SideMax];
      logic [7:0]    vals [SideMax*SideMax];
      logic [7:0]    mn [3], md [3], mx [3], z, v;
      int            n, half, j, sh, side;
      bit            med_in, pix_in;
      centre = ring_read(ox, oy);
      res = '{centre[23:16], centre[15:8], centre[7:0], amf_pkg::DEC_NONE, 1'b0};
      for (side = 1; side <= side_limit(); side += 2) begin
         half = side / 2;
         n = 0;
         for (int dy = -half; dy <= half; dy++)
            for (int dx = -half; dx <= half; dx++) begin
               win[n] = ring_read(ox + dx < 0 ? 0 : (ox + dx > w - 1 ? w - 1 : ox + dx),
                                  oy + dy < 0 ? 0 : (oy + dy > h - 1 ? h - 1 : oy + dy));
               n++;
            end
         med_in = 1; pix_in = 1;
         for (int c = 0; c < 3; c++) begin
            sh = 16 - 8 * c;
            for (int i = 0; i < n; i++) begin
               v = 8'(win[i] >> sh);
               j = i;
               while (j > 0 && vals[j-1] > v) begin
                  vals[j] = vals[j-1];
                  j--;
               end
               vals[j] = v;
            end
            mn[c] = vals[0]; md[c] = vals[n/2]; mx[c] = vals[n-1];
            z = 8'(centre >> sh);
            if (!(md[c] > mn[c] && md[c] < mx[c])) med_in = 0;
            if (!(z > mn[c] && z < mx[c])) pix_in = 0;
         end
         if (med_in) begin
            if (pix_in) res.decision = amf_pkg::DEC_KEEP;
            else res = '{md[0], md[1], md[2], amf_pkg::DEC_MEDIAN, 1'b0};
            break;
         end
      end
      return res;
   endfunction

   // Advance the raster by one request; return 1 when a filtered pixel comes out.
   function automatic bit filter_request(logic [7:0] r, g, b, logic fl,
                                         output pixel_result_type res);
      int unsigned w, h, need_x, need_y;
      w = width_used(); h = height_used();
      res = '0;
      if (!fl && in_row < h) begin
         line_ring[(in_row % RingRows) * amf_pkg::MaxWidth + in_col] = {r, g, b};
         in_col++;
         if (in_col >= w) begin
            in_col = 0; in_row++;
         end
      end
      if (out_row >= h) return 0;
      need_x = out_col + HalfMax; if (need_x > w - 1) need_x = w - 1;
      need_y = out_row + HalfMax; if (need_y > h - 1) need_y = h - 1;
      if (in_row < h && in_row * w + in_col <= need_y * w + need_x) return 0;
      res = filter_at(out_col, out_row, w, h);
      res.frame_last = (out_row == h - 1 && out_col == w - 1);
      out_col++;
      if (out_col >= w) begin
         out_col = 0; out_row++;
      end
      if (out_row >= h) restart_raster();
      return 1;
   endfunction

   // Offer one request, hold it until accepted, then record what it should yield.
   task automatic send_request(logic [7:0] r, g, b, logic fl, bit typed = 0,
                               bit has = 0, pixel_result_type given = '0);
      pixel_result_type res;
      bit            hit;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_red   <= r;
      req_pixel_green <= g;
      req_pixel_blue  <= b;
      req_flush_tick  <= fl;
      do @(posedge clock); while (req_stall);
      hit = filter_request(r, g, b, fl, res);
      if (typed) begin
         if (has) filtered_q.push_back(given);
      end else if (hit) begin
         filtered_q.push_back(res);
      end
      items_sent++;
      // switch idling profile by progress: sender light first, then receiver light, then none
      if (items_sent == 250) begin
         send_idle = 65; recv_idle = 31;
      end else if (items_sent == 500) begin
         send_idle = 0; recv_idle = 0;
      end
   endtask

   // Drain all results, wait until the block is idle, then write one register.
   task automatic write_register(logic [1:0] idx, logic [10:0] data);
      req_valid <= 1'b0;
      do @(posedge clock); while (filtered_q.size() != 0 || req_stall);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      update_register(idx, data);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] near_base();
      int v;
      v = int'(base_level) + int'($urandom_range(0, 6)) - 3;
      return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : 8'(v));
   endfunction

   // Mix of flat areas, impulse noise and uniform content.
   task automatic send_random_pixel(int mode);
      logic [7:0] r, g, b;
      case (mode)
         0: begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
         end
         1: begin
            r = near_base(); g = near_base(); b = near_base();
         end
         default: begin
            r = base_level; g = base_level; b = base_level;
            if ($urandom_range(3) == 0) begin
               r = $urandom_range(1) ? 8'hFF : 8'h00;
               g = $urandom_range(1) ? 8'hFF : 8'h00;
               b = 8'($urandom);
            end
         end
      endcase
      send_request(r, g, b, 1'b0);
   endtask

   // Receiver: random stall, or a long counted hold-off on request.
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_cnt  = 400;
         hold_seen = hold_req;
      end
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result r=%0d g=%0d b=%0d dec=%0d last=%0b",
                        rsp_out_red, rsp_out_green, rsp_out_blue, rsp_decision,
                        rsp_frame_last);
         end else begin
            want = filtered_q.pop_front();
            if (rsp_out_red !== want.red || rsp_out_green !== want.green ||
                rsp_out_blue !== want.blue || rsp_decision !== want.decision ||
                rsp_frame_last !== want.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected r=%0d g=%0d b=%0d dec=%0d last=%0b,",
                            " got r=%0d g=%0d b=%0d dec=%0d last=%0b"},
                           want.red, want.green, want.blue, want.decision, want.frame_last,
                           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_decision,
                           rsp_frame_last);
            end
         end
      end
   end

   initial begin
      #(150_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      stim_row_type dir [$];
      int        w_sel, h_sel, lim_sel, npix, mode, phase, waited;
      bit        forced, big, abandoned;
      reg_width = amf_pkg::WidthReset; reg_height = amf_pkg::HeightReset;
      reg_limit = amf_pkg::LimitReset;
      restart_raster();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. A 1x1 frame replicates one pixel, so no window is ever
      // accepted and the pixel comes back untouched as the last of its frame.
      dir = '{
         '{ROW_REG, amf_pkg::CSR_WIDTH, 11'd1, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_REG, amf_pkg::CSR_HEIGHT, 11'd1, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_REG, amf_pkg::CSR_LIMIT, 11'd3, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0, 0, 1, 1,
           '{8'd0, 8'd0, 8'd0, amf_pkg::DEC_NONE, 1'b1}},
         '{ROW_PIXEL, 0, 0, 8'd255, 8'd255, 8'd255, 0, 1, 1,
           '{8'd255, 8'd255, 8'd255, amf_pkg::DEC_NONE, 1'b1}},
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0, 1, 1, 0, '0},
         '{ROW_REG, amf_pkg::CSR_LIMIT, 11'd0, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd12, 8'd34, 8'd56, 0, 1, 1,
           '{8'd12, 8'd34, 8'd56, amf_pkg::DEC_NONE, 1'b1}},
         '{ROW_REG, amf_pkg::CSR_LIMIT, 11'd15, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_REG, amf_pkg::CSR_WIDTH, 11'd3, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_REG, amf_pkg::CSR_HEIGHT, 11'd2, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd255, 8'd0, 8'd255, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd255, 8'd0, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd128, 8'd1, 8'd254, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd7, 8'd200, 8'd90, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd255, 8'd255, 8'd255, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd9, 8'd9, 8'd9, 0, 0, 0, '0},   // dropped, frame is in
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0, 1, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0, 1, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0, 1, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0, 1, 0, 0, '0},
         '{ROW_REG, CsrUnused, 11'd5, 0, 0, 0, 0, 0, 0, '0},    // unused index: no effect
         '{ROW_REG, amf_pkg::CSR_LIMIT, 11'd4, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_REG, amf_pkg::CSR_WIDTH, 11'd4, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_REG, amf_pkg::CSR_HEIGHT, 11'd3, 0, 0, 0, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd10, 8'd200, 8'd30, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd11, 8'd0, 8'd31, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd255, 8'd201, 8'd32, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd12, 8'd199, 8'd0, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd13, 8'd200, 8'd255, 0, 0, 0, '0},
         '{ROW_PIXEL, 0, 0, 8'd10, 8'd202, 8'd33, 0, 0, 0, '0}
      };
      foreach (dir[i]) begin
         if (dir[i].kind == ROW_REG) write_register(dir[i].reg_index, dir[i].reg_data);
         else send_request(dir[i].red, dir[i].green, dir[i].blue, dir[i].flush,
                           dir[i].typed, dir[i].has_result, dir[i].result);
      end

      // Random frames; the register write of each phase abandons any open frame.
      phase = 0;
      while (items_sent < 720) begin
         w_sel = $urandom_range(1, 8);
         h_sel = $urandom_range(1, 6);
         lim_sel = $urandom_range(99) < 70 ? $urandom_range(2, 6) : $urandom_range(0, 15);
         big = 0;
         case ($urandom_range(19))
            0: begin w_sel = 0; h_sel = $urandom_range(0, 3); end
            1: begin
               w_sel = $urandom_range(1) ? 2047 : 1024; h_sel = 1; lim_sel = 3; big = 1;
            end
            2: begin
               w_sel = 1; h_sel = $urandom_range(1) ? 2047 : 1024; lim_sel = 3; big = 1;
            end
            default: ;
         endcase
         forced = (phase == 1 || phase == 3 || phase == 5);
         if (forced) begin
            w_sel = 8; h_sel = 6; lim_sel = 11; big = 0;
         end
         write_register(amf_pkg::CSR_WIDTH, 11'(w_sel));
         write_register(amf_pkg::CSR_HEIGHT, 11'(h_sel));
         write_register(amf_pkg::CSR_LIMIT, 11'(lim_sel));
         if ($urandom_range(4) == 0) write_register(CsrUnused, 11'($urandom));
         base_level = 8'($urandom);
         mode = $urandom_range(2);
         npix = width_used() * height_used();
         abandoned = 0;
         if (phase == 3) hold_req++;   // long receiver hold-off while requests keep coming
         for (int k = 0; k < npix; k++) begin
            if (phase == 5 && k == 2) begin
               // hold requests until every pending pixel has come back
               req_valid <= 1'b0;
               while (filtered_q.size() != 0) @(posedge clock);
            end
            if ($urandom_range(99) < 8)
               send_request(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            if ((big && k == 24) || (!forced && $urandom_range(99) < 3)) begin
               abandoned = 1;   // abandon this frame
               break;
            end
            send_random_pixel(mode);
         end
         waited = 0;
         while (!abandoned && raster_busy() && waited < 2100) begin
            // a stray pixel here is dropped and acts as a flush
            if ($urandom_range(9) == 0)
               send_request(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            else send_request(8'd0, 8'd0, 8'd0, 1'b1);
            waited++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      waited = 0;
      while (filtered_q.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (Settle) @(posedge clock);
      if (mismatches == 0 && filtered_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/amf_pkg.sv
rtl/core/amf_ram.sv
rtl/core/amf_rank.sv
rtl/core/adaptive_median_filter_rgb.sv
tb/tb_top.sv
